// ===== hw/rtl/smm_pkg.sv =====
// ============================================================================
// smm_pkg
// Shared types and constants of the segmented memory manager.
// ============================================================================
package smm_pkg;

  localparam int MaxSegments    = 64;
  localparam int MaxSegWords    = 1024;
  localparam int IdW            = 6;
  localparam int OffW           = 10;
  localparam int LenW           = 11;
  localparam int AddrW          = IdW + OffW;
  localparam int DataW          = 32;
  localparam int ModeW          = 3;
  localparam int StatusW        = 3;

  localparam logic [ModeW-1:0] MODE_MAP   = 3'd0;
  localparam logic [ModeW-1:0] MODE_UNMAP = 3'd1;
  localparam logic [ModeW-1:0] MODE_LOAD  = 3'd2;
  localparam logic [ModeW-1:0] MODE_STORE = 3'd3;
  localparam logic [ModeW-1:0] MODE_DUP   = 3'd4;

  localparam logic [StatusW-1:0] ST_OK         = 3'd0;
  localparam logic [StatusW-1:0] ST_BAD_ID     = 3'd1;
  localparam logic [StatusW-1:0] ST_BAD_OFFSET = 3'd2;
  localparam logic [StatusW-1:0] ST_NO_ID      = 3'd3;
  localparam logic [StatusW-1:0] ST_TOO_LONG   = 3'd4;
  localparam logic [StatusW-1:0] ST_UNMAPPED   = 3'd5;

  typedef struct packed {
    logic capture;
    logic decide;
    logic rd_issue;
    logic rd_take;
    logic copy_rd;
    logic copy_wr;
    logic fill_wr;
  } smm_cmd_t;

  typedef struct packed {
    logic walk;
    logic fill;
    logic copy;
    logic load;
    logic walk_done;
  } smm_stat_t;

endpackage

// ===== hw/rtl/smm_ctrl.sv =====
// ============================================================================
// smm_ctrl
// Sequencer: capture a request, decide, walk fill or copy or read a load word, deliver result.
// ============================================================================
module smm_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output smm_pkg::smm_cmd_t cmd,
  input  smm_pkg::smm_stat_t stat
);
  import smm_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_FILL = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state, state_next;
  logic       copy_ph, copy_ph_next;

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    state_next   = state;
    copy_ph_next = copy_ph;
    cmd          = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DEC;
        end
      end
      S_DEC: begin
        cmd.decide = 1'b1;
        if (stat.walk && stat.fill) begin
          state_next = S_FILL;
        end else if (stat.walk && stat.copy) begin
          state_next   = S_COPY;
          copy_ph_next = 1'b0;
        end else if (stat.load) begin
          cmd.rd_issue = 1'b1;
          state_next   = S_RD;
        end else begin
          state_next = S_OUT;
        end
      end
      S_FILL: begin
        if (stat.walk_done) begin
          state_next = S_OUT;
        end else begin
          cmd.fill_wr = 1'b1;
        end
      end
      S_COPY: begin
        if (!copy_ph) begin
          if (stat.walk_done) begin
            state_next = S_OUT;
          end else begin
            cmd.copy_rd  = 1'b1;
            copy_ph_next = 1'b1;
          end
        end else begin
          cmd.copy_wr  = 1'b1;
          copy_ph_next = 1'b0;
        end
      end
      S_RD: begin
        cmd.rd_take = 1'b1;
        state_next  = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      copy_ph <= 1'b0;
    end else begin
      state   <= state_next;
      copy_ph <= copy_ph_next;
    end
  end

endmodule

// ===== hw/rtl/smm_dpath.sv =====
// ============================================================================
// smm_dpath
// Segment table, free id ring, word memory and result registers.
// ============================================================================
module smm_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smm_pkg::LenW-1:0]      cfg_data,
  input  logic [smm_pkg::ModeW-1:0]     mode,
  input  logic [smm_pkg::IdW-1:0]       segment_id,
  input  logic [smm_pkg::OffW-1:0]      word_offset,
  input  logic [smm_pkg::DataW-1:0]     store_value,
  input  logic [smm_pkg::LenW-1:0]      map_length,
  input  smm_pkg::smm_cmd_t             cmd,
  output smm_pkg::smm_stat_t            stat,
  output logic [smm_pkg::StatusW-1:0]   status,
  output logic [smm_pkg::IdW-1:0]       new_segment_id,
  output logic [smm_pkg::DataW-1:0]     read_data
);
  import smm_pkg::*;

  logic [DataW-1:0] mem [0:(1<<AddrW)-1];
  logic [IdW-1:0]   ring [0:MaxSegments-1];
  logic [LenW-1:0]  seg_len [0:MaxSegments-1];
  logic [MaxSegments-1:0] mapped;
  logic [IdW-1:0]   q_head, q_tail;
  logic [IdW:0]     q_count, fresh;

  logic [ModeW-1:0] r_mode;
  logic [IdW-1:0]   r_id;
  logic [OffW-1:0]  r_off;
  logic [DataW-1:0] r_val;
  logic [LenW-1:0]  r_count;
  logic [LenW-1:0]  r_len;
  logic             r_mapped;
  logic [IdW-1:0]   r_qid;

  logic [StatusW-1:0] d_status;
  logic [IdW-1:0]     d_new;
  logic               d_fill, d_copy, d_load, d_store, d_unmap, d_pop, d_fresh;
  logic [LenW-1:0]    walk_len;
  logic [LenW-1:0]    walk_cnt;
  logic [IdW-1:0]     walk_id;
  logic [DataW-1:0]   mem_q;
  logic [LenW-1:0]    cfg_sat;

  assign cfg_sat = (cfg_data > LenW'(MaxSegWords)) ? LenW'(MaxSegWords) : cfg_data;

  // decide on captured request and looked-up segment state
  always_comb begin
    d_status = ST_OK;
    d_new    = '0;
    d_fill   = 1'b0;
    d_copy   = 1'b0;
    d_load   = 1'b0;
    d_store  = 1'b0;
    d_unmap  = 1'b0;
    d_pop    = 1'b0;
    d_fresh  = 1'b0;
    case (r_mode)
      MODE_MAP: begin
        if (r_count > LenW'(MaxSegWords)) begin
          d_status = ST_TOO_LONG;
        end else if (q_count != '0) begin
          d_pop  = 1'b1;
          d_new  = r_qid;
          d_fill = 1'b1;
        end else if (fresh < (IdW+1)'(MaxSegments)) begin
          d_fresh = 1'b1;
          d_new   = fresh[IdW-1:0];
          d_fill  = 1'b1;
        end else begin
          d_status = ST_NO_ID;
        end
      end
      MODE_UNMAP: begin
        if ({1'b0, r_id} >= fresh) d_status = ST_BAD_ID;
        else d_unmap = r_mapped;
      end
      MODE_LOAD, MODE_STORE, MODE_DUP: begin
        if ({1'b0, r_id} >= fresh) d_status = ST_BAD_ID;
        else if (!r_mapped) d_status = ST_UNMAPPED;
        else if (r_mode == MODE_DUP) d_copy = (r_id != '0);
        else if ({1'b0, r_off} >= r_len) d_status = ST_BAD_OFFSET;
        else if (r_mode == MODE_LOAD) d_load = 1'b1;
        else d_store = 1'b1;
      end
      default: d_status = ST_OK;
    endcase
  end

  assign stat.walk      = d_fill | d_copy;
  assign stat.fill      = d_fill;
  assign stat.copy      = d_copy;
  assign stat.load      = d_load;
  assign stat.walk_done = (walk_cnt == walk_len);

  // request capture, table lookup
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      r_mode   <= mode;
      r_id     <= segment_id;
      r_off    <= word_offset;
      r_val    <= store_value;
      r_count  <= map_length;
      r_len    <= seg_len[segment_id];
      r_mapped <= mapped[segment_id];
      r_qid    <= ring[q_head];
    end
  end

  // walk setup and progress
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      walk_cnt <= '0;
      walk_len <= d_fill ? r_count : r_len;
      walk_id  <= d_new;
    end else if (cmd.fill_wr || cmd.copy_wr) begin
      walk_cnt <= walk_cnt + 1'b1;
    end
  end

  // word memory: one write and one read port
  always_ff @(posedge clk) begin
    if (cmd.fill_wr) begin
      mem[{walk_id, walk_cnt[OffW-1:0]}] <= '0;
    end else if (cmd.copy_wr) begin
      mem[{{IdW{1'b0}}, walk_cnt[OffW-1:0]}] <= mem_q;
    end else if (cmd.decide && d_store) begin
      mem[{r_id, r_off}] <= r_val;
    end
    if (cmd.copy_rd) begin
      mem_q <= mem[{r_id, walk_cnt[OffW-1:0]}];
    end else if (cmd.rd_issue) begin
      mem_q <= mem[{r_id, r_off}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide && d_unmap && r_id != '0 && q_count < (IdW+1)'(MaxSegments)) begin
      ring[q_tail] <= r_id;
    end
  end

  // segment table and id bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      seg_len[0] <= '0;
      mapped     <= MaxSegments'(1);
      q_head     <= '0;
      q_tail     <= '0;
      q_count    <= '0;
      fresh      <= (IdW+1)'(1);
    end else begin
      if (cfg_we) begin
        seg_len[0] <= cfg_sat;
        mapped[0]  <= 1'b1;
      end
      if (cmd.decide) begin
        if (d_pop) begin
          q_head  <= q_head + 1'b1;
          q_count <= q_count - 1'b1;
        end
        if (d_fresh) fresh <= fresh + 1'b1;
        if (d_fill) begin
          seg_len[d_new] <= r_count;
          mapped[d_new]  <= 1'b1;
        end
        if (d_unmap) begin
          seg_len[r_id] <= '0;
          mapped[r_id]  <= 1'b0;
          if (r_id != '0 && q_count < (IdW+1)'(MaxSegments)) begin
            q_tail  <= q_tail + 1'b1;
            q_count <= q_count + 1'b1;
          end
        end
        if (d_copy) begin
          seg_len[0] <= r_len;
          mapped[0]  <= 1'b1;
        end
      end
    end
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      status         <= d_status;
      new_segment_id <= d_new;
      read_data      <= '0;
    end else if (cmd.rd_take) begin
      read_data <= mem_q;
    end
  end

endmodule

// ===== hw/rtl/segmented_memory_manager_core.sv =====
// ============================================================================
// segmented_memory_manager_core
// Segmented word memory with map, unmap, load, store and duplicate.
// ============================================================================
// Requests enter on in_valid/in_stall; each transaction carries mode,
// segment_id, word_offset, store_value and map_length. Exactly one result
// transaction leaves on out_valid/out_stall with status, new_segment_id and
// read_data. One request is handled at a time: in_stall is high from the
// cycle after acceptance until the result is taken.
// After the decision, unmap, store and errors go straight to the result; a
// load adds one registered memory read; a map zero-fills map_length words,
// one word per cycle; a duplicate reads then writes each word of the source
// on the single word memory. The next request can be taken in the cycle after
// the result is taken.
// A stalled result holds and blocks the next request.
// Synchronous reset clears the mapped flags, segment 0 length, free id ring
// pointers and the sequencer; segment 0 starts mapped with length 0. Word
// memory is not cleared. cfg_we writes program_length (saturated to 1024)
// at any idle time.
// ============================================================================
module segmented_memory_manager_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [smm_pkg::LenW-1:0]      cfg_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [smm_pkg::ModeW-1:0]     mode,
  input  logic [smm_pkg::IdW-1:0]       segment_id,
  input  logic [smm_pkg::OffW-1:0]      word_offset,
  input  logic [smm_pkg::DataW-1:0]     store_value,
  input  logic [smm_pkg::LenW-1:0]      map_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [smm_pkg::StatusW-1:0]   status,
  output logic [smm_pkg::IdW-1:0]       new_segment_id,
  output logic [smm_pkg::DataW-1:0]     read_data
);
  import smm_pkg::*;

  smm_cmd_t  cmd;
  smm_stat_t stat;

  smm_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .stat
  );

  smm_dpath u_dpath (
    .clk, .rst, .cfg_we, .cfg_data, .mode, .segment_id, .word_offset,
    .store_value, .map_length, .cmd, .stat, .status, .new_segment_id,
    .read_data
  );

endmodule

// ===== hw/rtl/smm_checker.sv =====
// ============================================================================
// smm_checker
// Port-level checks of the segmented memory manager.
// ============================================================================
module smm_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [smm_pkg::StatusW-1:0] status,
  input logic [smm_pkg::IdW-1:0]     new_segment_id,
  input logic [smm_pkg::DataW-1:0]   read_data
);
  import smm_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(read_data))
    else $error("result changed while stalled");

  a_one_at_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken while busy");

  a_busy_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("request taken with result pending");

  a_new_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> new_segment_id == '0)
    else $error("id on failed request");

  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> read_data == '0)
    else $error("data on failed request");

endmodule

bind segmented_memory_manager_core smm_checker u_smm_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .status,
  .new_segment_id, .read_data
);

// ===== dv/segmented_memory_manager_core_tb.sv =====
// ============================================================================
// segmented_memory_manager_core_tb
// Self-checking bench for the segmented memory manager. A directed table
// covers bounds, identifier reuse, unmap and duplicate corner cases; random
// transactions then run against an internal prediction of the segment table,
// free identifier ring and word memory, across several program lengths, with
// random gaps and stalls on both channels.
// ============================================================================
module segmented_memory_manager_core_tb;
  import smm_pkg::*;

  localparam int CycleLimit = 12000000;
  localparam int RandItems  = 200;

  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic [IdW-1:0]     id;
    logic [OffW-1:0]    off;
    logic [DataW-1:0]   val;
    logic [LenW-1:0]    count;
    logic               chk;
    logic [StatusW-1:0] st;
    logic [IdW-1:0]     nid;
    logic [DataW-1:0]   data;
  } row_t;

  typedef struct packed {
    logic [StatusW-1:0] st;
    logic [IdW-1:0]     nid;
    logic [DataW-1:0]   data;
  } rsp_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_we = 1'b0;
  logic [LenW-1:0]    cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [ModeW-1:0]   mode = '0;
  logic [IdW-1:0]     segment_id = '0;
  logic [OffW-1:0]    word_offset = '0;
  logic [DataW-1:0]   store_value = '0;
  logic [LenW-1:0]    map_length = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [StatusW-1:0] status;
  logic [IdW-1:0]     new_segment_id;
  logic [DataW-1:0]   read_data;

  segmented_memory_manager_core u_top (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .mode(mode),
    .segment_id(segment_id), .word_offset(word_offset),
    .store_value(store_value), .map_length(map_length),
    .out_valid(out_valid), .out_stall(out_stall), .status(status),
    .new_segment_id(new_segment_id), .read_data(read_data)
  );

  // shadow of the block state
  logic [DataW-1:0] words [0:MaxSegments*MaxSegWords-1];
  bit               word_known [0:MaxSegments*MaxSegWords-1];
  int unsigned      seg_len [0:MaxSegments-1];
  bit               seg_live [0:MaxSegments-1];
  int unsigned      free_ids [$];
  int unsigned      next_id;

  rsp_t pending_rsp [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   quiet = 1'b0;
  int   stall_left = 0;

  row_t directed [0:24] = '{
    '{MODE_STORE, 6'd0,  10'd0,    32'hFFFF_FFFF, 11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_STORE, 6'd0,  10'd3,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_LOAD,  6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'hFFFF_FFFF},
    '{MODE_LOAD,  6'd0,  10'd4,    32'h0,         11'd0,    1'b1, ST_BAD_OFFSET, 6'd0, 32'd0},
    '{MODE_LOAD,  6'd1,  10'd0,    32'h0,         11'd0,    1'b1, ST_BAD_ID,     6'd0, 32'd0},
    '{MODE_UNMAP, 6'd63, 10'd0,    32'h0,         11'd0,    1'b1, ST_BAD_ID,     6'd0, 32'd0},
    '{MODE_DUP,   6'd63, 10'd0,    32'h0,         11'd0,    1'b1, ST_BAD_ID,     6'd0, 32'd0},
    '{MODE_MAP,   6'd0,  10'd0,    32'h0,         11'd1025, 1'b1, ST_TOO_LONG,   6'd0, 32'd0},
    '{MODE_MAP,   6'd0,  10'd0,    32'h0,         11'd2047, 1'b1, ST_TOO_LONG,   6'd0, 32'd0},
    '{MODE_MAP,   6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd1, 32'd0},
    '{MODE_MAP,   6'd0,  10'd0,    32'h0,         11'd1024, 1'b1, ST_OK,         6'd2, 32'd0},
    '{MODE_LOAD,  6'd2,  10'd1023, 32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_STORE, 6'd2,  10'd1023, 32'hA5A5_5A5A, 11'd0,    1'b0, ST_OK,         6'd0, 32'd0},
    '{MODE_LOAD,  6'd1,  10'd0,    32'h0,         11'd0,    1'b1, ST_BAD_OFFSET, 6'd0, 32'd0},
    '{MODE_UNMAP, 6'd1,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_UNMAP, 6'd1,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_LOAD,  6'd1,  10'd0,    32'h0,         11'd0,    1'b1, ST_UNMAPPED,   6'd0, 32'd0},
    '{MODE_MAP,   6'd0,  10'd0,    32'h0,         11'd3,    1'b1, ST_OK,         6'd1, 32'd0},
    '{MODE_DUP,   6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_DUP,   6'd2,  10'd0,    32'h0,         11'd0,    1'b0, ST_OK,         6'd0, 32'd0},
    '{MODE_LOAD,  6'd0,  10'd1023, 32'h0,         11'd0,    1'b0, ST_OK,         6'd0, 32'd0},
    '{3'd5,       6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{3'd7,       6'd63, 10'd1023, 32'hFFFF_FFFF, 11'd2047, 1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_UNMAP, 6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_OK,         6'd0, 32'd0},
    '{MODE_LOAD,  6'd0,  10'd0,    32'h0,         11'd0,    1'b1, ST_UNMAPPED,   6'd0, 32'd0}
  };

  function automatic void apply_program_length(input int unsigned v);
    if (v > MaxSegWords) v = MaxSegWords;
    seg_len[0]  = v;
    seg_live[0] = 1'b1;
  endfunction

  function automatic logic [StatusW-1:0] target_status(input int unsigned id);
    if (id >= next_id) return ST_BAD_ID;
    if (!seg_live[id]) return ST_UNMAPPED;
    return ST_OK;
  endfunction

  function automatic rsp_t segment_op(input row_t r);
    rsp_t        o;
    int unsigned id;
    int unsigned base;
    id   = r.id;
    base = id * MaxSegWords;
    o    = '0;
    case (r.mode)
      MODE_MAP: begin
        if (r.count > MaxSegWords) begin
          o.st = ST_TOO_LONG;
        end else if (free_ids.size() == 0 && next_id >= MaxSegments) begin
          o.st = ST_NO_ID;
        end else begin
          if (free_ids.size() > 0) id = free_ids.pop_front();
          else begin
            id = next_id;
            next_id++;
          end
          for (int k = 0; k < r.count; k++) begin
            words[id*MaxSegWords+k]      = '0;
            word_known[id*MaxSegWords+k] = 1'b1;
          end
          seg_len[id]  = r.count;
          seg_live[id] = 1'b1;
          o.nid        = IdW'(id);
        end
      end
      MODE_UNMAP: begin
        if (id >= next_id) o.st = ST_BAD_ID;
        else if (seg_live[id]) begin
          seg_live[id] = 1'b0;
          seg_len[id]  = 0;
          if (id != 0) free_ids.push_back(id);
        end
      end
      MODE_LOAD, MODE_STORE: begin
        o.st = target_status(id);
        if (o.st == ST_OK && r.off >= seg_len[id]) o.st = ST_BAD_OFFSET;
        if (o.st == ST_OK) begin
          if (r.mode == MODE_LOAD) o.data = words[base+r.off];
          else begin
            words[base+r.off]      = r.val;
            word_known[base+r.off] = 1'b1;
          end
        end
      end
      MODE_DUP: begin
        o.st = target_status(id);
        if (o.st == ST_OK && id != 0) begin
          for (int k = 0; k < seg_len[id]; k++) begin
            words[k]      = words[base+k];
            word_known[k] = word_known[base+k];
          end
          seg_len[0]  = seg_len[id];
          seg_live[0] = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic row_t random_request();
    row_t        r;
    int          p;
    int unsigned addr;
    r = '0;
    p = $urandom_range(0, 99);
    r.val = $urandom;
    if (p < 22) r.mode = MODE_MAP;
    else if (p < 36) r.mode = MODE_UNMAP;
    else if (p < 60) r.mode = MODE_LOAD;
    else if (p < 84) r.mode = MODE_STORE;
    else if (p < 92) r.mode = MODE_DUP;
    else r.mode = ModeW'($urandom_range(5, 7));
    if ($urandom_range(0, 99) < 85) r.id = IdW'($urandom_range(0, next_id - 1));
    else r.id = IdW'($urandom_range(0, MaxSegments - 1));
    if (seg_live[r.id] && seg_len[r.id] > 0 && $urandom_range(0, 99) < 85)
      r.off = OffW'($urandom_range(0, seg_len[r.id] - 1));
    else r.off = OffW'($urandom_range(0, MaxSegWords - 1));
    p = $urandom_range(0, 99);
    if (p < 70) r.count = LenW'($urandom_range(0, 8));
    else if (p < 86) r.count = LenW'($urandom_range(9, 64));
    else if (p < 93) r.count = LenW'($urandom_range(1000, MaxSegWords));
    else r.count = LenW'($urandom_range(0, 2047));
    addr = r.id * MaxSegWords + r.off;
    if (r.mode == MODE_LOAD && target_status(r.id) == ST_OK && r.off < seg_len[r.id]
        && !word_known[addr])
      r.mode = MODE_STORE;
    return r;
  endfunction

  task automatic issue_request(input row_t r);
    rsp_t predicted;
    int   g;
    mode        <= r.mode;
    segment_id  <= r.id;
    word_offset <= r.off;
    store_value <= r.val;
    map_length  <= r.count;
    in_valid    <= 1'b1;
    do @(posedge clk); while (in_stall);
    predicted = segment_op(r);
    if (r.chk) pending_rsp.push_back(rsp_t'{r.st, r.nid, r.data});
    else pending_rsp.push_back(predicted);
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_rsp.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_program_length(input int unsigned v);
    cfg_data <= LenW'(v);
    cfg_we   <= 1'b1;
    @(posedge clk);
    apply_program_length(v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left > 0) stall_left--;
      else if ($urandom_range(0, 5) == 0) stall_left = gap_len();
      out_stall <= (stall_left > 0);
      if (out_valid && !out_stall) begin
        if (pending_rsp.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction: status %0d", status);
        end else begin
          rsp_t e;
          e = pending_rsp.pop_front();
          if (status !== e.st || new_segment_id !== e.nid || read_data !== e.data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp st %0d id %0d data %h, got st %0d id %0d data %h",
                       e.st, e.nid, e.data, status, new_segment_id, read_data);
          end
        end
      end
    end
  end

  initial begin
    int unsigned lengths [0:5];
    for (int k = 0; k < MaxSegments; k++) begin
      seg_len[k]  = 0;
      seg_live[k] = 1'b0;
    end
    seg_live[0] = 1'b1;
    next_id     = 1;
    lengths     = '{4, 2047, 0, 1024, 1, 0};
    lengths[5]  = $urandom_range(0, 2047);
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 6; ph++) begin
      write_program_length(lengths[ph]);
      if (ph == 0)
        foreach (directed[i]) issue_request(directed[i]);
      for (int n = 0; n < RandItems; n++) begin
        if (n % 60 == 0) quiet = ($urandom_range(0, 2) == 0);
        if (ph == 2 && n % 40 == 39) drain();
        issue_request(random_request());
      end
      drain();
    end
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
